@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, disabled in reset
`define TTB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication, disabled in reset
`define TTB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define TTB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ttb_pkg.sv @@
// types, constants and helpers for the triangle tangent/bitangent block
// no dependencies
package ttb_pkg;

  localparam int DELTA_W = 33;
  localparam int PROD_W  = 2 * DELTA_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int QDEPTH  = 2;

  typedef struct packed {
    logic               mesh_start;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               degenerate;
  } out_beat_t;

  // one triangle's work, passed from front to back
  typedef struct packed {
    logic [2:0][DELTA_W-1:0] e1;
    logic [2:0][DELTA_W-1:0] e2;
    logic [DELTA_W-1:0]      du1;
    logic [DELTA_W-1:0]      dv1;
    logic [DELTA_W-1:0]      du2;
    logic [DELTA_W-1:0]      dv2;
    logic [2:0][31:0]        n0;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEN_A, S_DEN_B, S_DEN_C, S_NUM_A, S_NUM_B, S_NUM_C,
    S_DIV, S_BT_A, S_BT_B, S_BT_C, S_OUT
  } back_state_t;

  localparam logic [1:0] SLOT_V0     = 2'd0;
  localparam logic [1:0] SLOT_V1     = 2'd1;
  localparam logic [1:0] SLOT_V2     = 2'd2;
  localparam logic [1:0] SLOT_UNUSED = 2'd3;

  // saturate a wide signed value to 32 bits
  function automatic logic [31:0] sat32(input logic [SUM_W-1:0] x);
    logic [31:0] r;
    if (!x[SUM_W-1] && (|x[SUM_W-2:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (x[SUM_W-1] && !(&x[SUM_W-2:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/ttb_front.sv @@
// front: groups vertices in threes, holds v0/v1 and forms triangle deltas
// depends on ttb_pkg, assert_macros.svh
`include "assert_macros.svh"
module ttb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  ttb_pkg::in_beat_t in_data,
  output logic             push,
  output ttb_pkg::job_t    job
);
  import ttb_pkg::*;

  logic [1:0]       slot_r, slot_nxt, slot_eff;
  logic [7:0][31:0] f_r;
  logic [4:0][31:0] s_r;
  logic [7:0][31:0] v;

  assign v = {in_data.norm_z, in_data.norm_y, in_data.norm_x, in_data.tex_v,
              in_data.tex_u, in_data.pos_z, in_data.pos_y, in_data.pos_x};

  // restart on mesh start or unused slot code
  always_comb begin
    slot_eff = (in_data.mesh_start || slot_r == SLOT_UNUSED) ? SLOT_V0 : slot_r;
    slot_nxt = slot_r;
    if (in_fire) begin
      case (slot_eff)
        SLOT_V0: slot_nxt = SLOT_V1;
        SLOT_V1: slot_nxt = SLOT_V2;
        default: slot_nxt = SLOT_V0;
      endcase
    end
  end

  assign push = in_fire && (slot_eff == SLOT_V2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= SLOT_V0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  // vertex stores
  always_ff @(posedge clk) begin
    if (in_fire && slot_eff == SLOT_V0) f_r <= v;
    if (in_fire && slot_eff == SLOT_V1) s_r <= v[4:0];
  end

  // deltas against v0
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      job.e1[i] = DELTA_W'($signed(s_r[i])) - DELTA_W'($signed(f_r[i]));
      job.e2[i] = DELTA_W'($signed(v[i]))   - DELTA_W'($signed(f_r[i]));
      job.n0[i] = f_r[5+i];
    end
    job.du1 = DELTA_W'($signed(s_r[3])) - DELTA_W'($signed(f_r[3]));
    job.dv1 = DELTA_W'($signed(s_r[4])) - DELTA_W'($signed(f_r[4]));
    job.du2 = DELTA_W'($signed(v[3]))   - DELTA_W'($signed(f_r[3]));
    job.dv2 = DELTA_W'($signed(v[4]))   - DELTA_W'($signed(f_r[4]));
  end

  `TTB_ASSERT_NEXT(a_push_rewinds, clk, rst_n, push, slot_r == SLOT_V0, "slot not rewound")
  `TTB_ASSERT(a_slot_legal, clk, rst_n, slot_r != SLOT_UNUSED, "unused slot code reached")

endmodule

@@ rtl/ttb_queue.sv @@
// short job queue between front and back
// depends on ttb_pkg, assert_macros.svh
`include "assert_macros.svh"
module ttb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ttb_pkg::job_t push_job,
  output logic          full,
  output logic          avail,
  input  logic          pop,
  output ttb_pkg::job_t pop_job
);
  import ttb_pkg::*;

  job_t       mem [QDEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'(QDEPTH));
  assign avail   = (cnt_r != 2'd0);
  assign pop_job = mem[rp_r];

  // pointers and fill count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_job;
  end

  `TTB_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= 2'(QDEPTH), "queue over depth")
  `TTB_ASSERT_IMP(a_no_overrun, clk, rst_n, full, !push, "push into full queue")
  `TTB_ASSERT_IMP(a_no_underrun, clk, rst_n, !avail, !pop, "pop from empty queue")

endmodule

@@ rtl/ttb_back.sv @@
// back: shared multiplier, bit-serial divider and cross product per triangle
// depends on ttb_pkg, assert_macros.svh
`include "assert_macros.svh"
module ttb_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               avail,
  input  ttb_pkg::job_t      job_in,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ttb_pkg::out_beat_t out_data
);
  import ttb_pkg::*;

  localparam int NSH_W = SUM_W + FRAC_BITS;
  localparam int HI_W  = NSH_W - 32;

  back_state_t              state_r, state_nxt;
  job_t                     job_r;
  logic [1:0]               comp_r;
  logic [PROD_W-1:0]        prod_r, acc_r;
  logic signed [PROD_W-1:0] prod;
  logic [SUM_W-1:0]         diff;
  logic [SUM_W-1:0]         dmag_r, nmag, rem_r;
  logic                     dneg_r, neg_r, ovf_r, degen_r;
  logic [31:0]              lo_r, q_r, q_fin, t_sat;
  logic [4:0]               bit_cnt_r;
  logic [SUM_W:0]           trial;
  logic                     qbit;
  logic [NSH_W-1:0]         nsh;
  logic [HI_W-1:0]          nhi;
  logic [SUM_W-1:0]         bsh;
  logic [2:0][31:0]         tan_r, bit_r;
  logic [DELTA_W-1:0]       op_a, op_b;

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_DEN_A: begin op_a = job_r.du1; op_b = job_r.dv2; end
      S_DEN_B: begin op_a = job_r.dv1; op_b = job_r.du2; end
      S_NUM_A: begin op_a = job_r.e1[comp_r]; op_b = job_r.dv2; end
      S_NUM_B: begin op_a = job_r.e2[comp_r]; op_b = job_r.dv1; end
      S_BT_A: begin
        case (comp_r)
          2'd0: begin
            op_a = DELTA_W'($signed(tan_r[1]));
            op_b = DELTA_W'($signed(job_r.n0[2]));
          end
          2'd1: begin
            op_a = DELTA_W'($signed(tan_r[2]));
            op_b = DELTA_W'($signed(job_r.n0[0]));
          end
          default: begin
            op_a = DELTA_W'($signed(tan_r[0]));
            op_b = DELTA_W'($signed(job_r.n0[1]));
          end
        endcase
      end
      S_BT_B: begin
        case (comp_r)
          2'd0: begin
            op_a = DELTA_W'($signed(tan_r[2]));
            op_b = DELTA_W'($signed(job_r.n0[1]));
          end
          2'd1: begin
            op_a = DELTA_W'($signed(tan_r[0]));
            op_b = DELTA_W'($signed(job_r.n0[2]));
          end
          default: begin
            op_a = DELTA_W'($signed(tan_r[1]));
            op_b = DELTA_W'($signed(job_r.n0[0]));
          end
        endcase
      end
      default: ;
    endcase
  end

  // full-width signed product
  assign prod = $signed(op_a) * $signed(op_b);

  // difference of the two held products, and divider setup
  always_comb begin
    diff  = {acc_r[PROD_W-1], acc_r} - {prod_r[PROD_W-1], prod_r};
    nmag  = diff[SUM_W-1] ? (~diff + 1'b1) : diff;
    nsh   = {nmag, {FRAC_BITS{1'b0}}};
    nhi   = nsh[NSH_W-1:32];
    trial = {rem_r, lo_r[31]};
    qbit  = (trial >= {1'b0, dmag_r});
    q_fin = {q_r[30:0], qbit};
    bsh   = SUM_W'($signed(diff) >>> FRAC_BITS);
  end

  // saturate the unsigned quotient with its sign
  always_comb begin
    if (!neg_r) begin
      t_sat = (ovf_r || q_fin[31]) ? 32'h7FFF_FFFF : q_fin;
    end else begin
      t_sat = (ovf_r || q_fin > 32'h8000_0000) ? 32'h8000_0000 : (~q_fin + 1'b1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (avail) state_nxt = S_DEN_A;
      S_DEN_A: state_nxt = S_DEN_B;
      S_DEN_B: state_nxt = S_DEN_C;
      S_DEN_C: state_nxt = (diff == '0) ? S_OUT : S_NUM_A;
      S_NUM_A: state_nxt = S_NUM_B;
      S_NUM_B: state_nxt = S_NUM_C;
      S_NUM_C: state_nxt = S_DIV;
      S_DIV: begin
        if (bit_cnt_r == 5'd0) state_nxt = (comp_r == 2'd2) ? S_BT_A : S_NUM_A;
      end
      S_BT_A:  state_nxt = S_BT_B;
      S_BT_B:  state_nxt = S_BT_C;
      S_BT_C:  state_nxt = (comp_r == 2'd2) ? S_OUT : S_BT_A;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    pop       = (state_r == S_IDLE) && avail;
    out_valid = (state_r == S_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= prod;
    case (state_r)
      S_IDLE: begin
        job_r   <= job_in;
        comp_r  <= 2'd0;
        degen_r <= 1'b0;
        tan_r   <= '0;
        bit_r   <= '0;
      end
      S_DEN_B, S_NUM_B, S_BT_B: acc_r <= prod_r;
      S_DEN_C: begin
        degen_r <= (diff == '0);
        dneg_r  <= diff[SUM_W-1];
        dmag_r  <= nmag;
      end
      S_NUM_C: begin
        neg_r     <= diff[SUM_W-1] ^ dneg_r;
        ovf_r     <= (SUM_W'(nhi) >= dmag_r);
        rem_r     <= SUM_W'(nhi);
        lo_r      <= nsh[31:0];
        q_r       <= '0;
        bit_cnt_r <= 5'd31;
      end
      S_DIV: begin
        rem_r     <= qbit ? SUM_W'(trial - {1'b0, dmag_r}) : trial[SUM_W-1:0];
        lo_r      <= {lo_r[30:0], 1'b0};
        q_r       <= q_fin;
        bit_cnt_r <= bit_cnt_r - 5'd1;
        if (bit_cnt_r == 5'd0) begin
          tan_r[comp_r] <= t_sat;
          comp_r        <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
        end
      end
      S_BT_C: begin
        bit_r[comp_r] <= sat32(bsh);
        comp_r        <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data.tangent_x   = tan_r[0];
    out_data.tangent_y   = tan_r[1];
    out_data.tangent_z   = tan_r[2];
    out_data.bitangent_x = bit_r[0];
    out_data.bitangent_y = bit_r[1];
    out_data.bitangent_z = bit_r[2];
    out_data.degenerate  = degen_r;
  end

  `TTB_ASSERT_IMP(a_degen_zero, clk, rst_n, out_valid && degen_r, tan_r == '0 && bit_r == '0, "degenerate result not zero")
  `TTB_ASSERT_IMP(a_div_nonzero, clk, rst_n, state_r == S_DIV, dmag_r != '0, "divide by zero")
  `TTB_ASSERT_IMP(a_rem_below, clk, rst_n, state_r == S_DIV && !ovf_r, rem_r < dmag_r, "remainder not reduced")

endmodule

@@ rtl/triangle_tangent_bitangent.sv @@
// one triangle every 3 vertices; the front takes a vertex a cycle, while not full,
// into a 2-deep job queue; the back works one triangle at a time: denominator, then per
// tangent component a numerator and a bit-serial divide, then the bitangent cross product,
// then output, with all products on one shared multiplier; it pops the next job from idle
// only; degenerate triangles go straight to output with zeros; reset is synchronous, active
// low, and clears grouping, queue and sequencer; vertex stores are unset until written
module triangle_tangent_bitangent #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ttb_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ttb_pkg::out_beat_t out_data
);
  import ttb_pkg::*;

  logic in_fire, push, full, avail, pop;
  job_t push_job, pop_job;

  // a vertex beat is taken whenever the queue has room
  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;

  ttb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .push    (push),
    .job     (push_job)
  );

  ttb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .avail    (avail),
    .pop      (pop),
    .pop_job  (pop_job)
  );

  ttb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .avail     (avail),
    .job_in    (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
